FILE: rtl/hsc_pkg.sv
// ----------------------------------------------------------------------------
// hsc_pkg
// shared constants and types of the five-point heat stencil stream
// ----------------------------------------------------------------------------
package hsc_pkg;

	// grid geometry
	localparam int MAX_WIDTH  = 1024;
	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int GW_W       = 11;
	localparam int GH_W       = 16;
	localparam int ROW_W      = 16;
	localparam int MIN_DIM    = 3;
	localparam int RESET_DIM  = 1024;

	// sample datapath
	localparam int SAMPLE_W   = 32;
	localparam int SUM_W      = SAMPLE_W + 3;

	// configuration port
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = CFG_IDX_W'(1);

	// front to back queue
	localparam int Q_DEPTH    = 4;
	localparam int QPTR_W     = $clog2(Q_DEPTH);
	localparam int QCNT_W     = $clog2(Q_DEPTH + 1);

	// one queued entry: the stencil result and, on the last row, the copy of the input
	typedef struct packed {
		logic signed [SAMPLE_W-1:0] value;
		logic signed [SAMPLE_W-1:0] copy_value;
		logic [COL_W-1:0]           column;
		logic [ROW_W-1:0]           row;
		logic                       two;
		logic                       frame_end;
	} q_entry_t;

endpackage

FILE: rtl/hsc_ram.sv
// ----------------------------------------------------------------------------
// hsc_ram
// generic simple dual port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module hsc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// read returns old data on a same-address write
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

FILE: rtl/hsc_queue.sv
// ----------------------------------------------------------------------------
// hsc_queue
// short register queue between the stencil front and the result back
// ----------------------------------------------------------------------------
module hsc_queue import hsc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_push,
	input  q_entry_t          q_din,
	input  logic              q_pop,
	output q_entry_t          q_dout,
	output logic              q_empty,
	output logic [QCNT_W-1:0] q_count
);

	q_entry_t          mem_q [Q_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	always_ff @(posedge clk) begin
		if (q_push) begin
			mem_q[wr_ptr_q] <= q_din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (q_push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (q_pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			unique case ({q_push, q_pop})
				2'b10:   count_q <= count_q + QCNT_W'(1);
				2'b01:   count_q <= count_q - QCNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	assign q_dout  = mem_q[rd_ptr_q];
	assign q_empty = (count_q == '0);
	assign q_count = count_q;

endmodule

FILE: rtl/hsc_front.sv
// ----------------------------------------------------------------------------
// hsc_front
// geometry registers, raster counters, line stores and the stencil datapath
// ----------------------------------------------------------------------------
module hsc_front import hsc_pkg::*; (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [CFG_IDX_W-1:0]        cfg_index,
	input  logic [CFG_DATA_W-1:0]       cfg_data,
	input  logic                        push,
	output logic                        full,
	input  logic signed [SAMPLE_W-1:0]  sample,
	input  logic [QCNT_W-1:0]           q_count,
	output logic                        q_push,
	output q_entry_t                    q_din,
	output logic                        valid_s1
);

	logic [GW_W-1:0]  width_q;
	logic [GH_W-1:0]  height_q;
	logic [GW_W-1:0]  eff_w;
	logic [GH_W-1:0]  eff_h;
	logic [GW_W-1:0]  last_col_w;
	logic [COL_W-1:0] last_col;
	logic [ROW_W-1:0] last_row;
	logic             cfg_hit;
	logic             accept;

	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;

	logic [COL_W-1:0]           col_s1;
	logic [ROW_W-1:0]           ry_s1;
	logic                       has_res_s1;
	logic                       border_s1;
	logic                       last_row_s1;
	logic                       end_s1;
	logic signed [SAMPLE_W-1:0] sample_s1;

	logic signed [SAMPLE_W-1:0] mid;
	logic signed [SAMPLE_W-1:0] rgt;
	logic signed [SAMPLE_W-1:0] up;
	logic signed [SAMPLE_W-1:0] lft_q;
	logic signed [SUM_W-1:0]    sum;
	logic [QCNT_W:0]            fill;

	// geometry registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= GW_W'(RESET_DIM);
			height_q <= GH_W'(RESET_DIM);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_GRID_WIDTH:  width_q  <= cfg_data[GW_W-1:0];
				CFG_GRID_HEIGHT: height_q <= cfg_data[GH_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg_ready = 1'b1;
	assign cfg_hit   = cfg_valid && (cfg_index == CFG_GRID_WIDTH ||
		cfg_index == CFG_GRID_HEIGHT);

	always_comb begin
		if (width_q < GW_W'(MIN_DIM)) begin
			eff_w = GW_W'(MIN_DIM);
		end else if (width_q > GW_W'(MAX_WIDTH)) begin
			eff_w = GW_W'(MAX_WIDTH);
		end else begin
			eff_w = width_q;
		end
		eff_h = (height_q < GH_W'(MIN_DIM)) ? GH_W'(MIN_DIM) : height_q;
	end

	assign last_col_w = eff_w - GW_W'(1);
	assign last_col   = last_col_w[COL_W-1:0];
	assign last_row   = eff_h - GH_W'(1);

	// room for the item now in s1 plus the new one
	assign fill   = {1'b0, q_count} + {{QCNT_W{1'b0}}, valid_s1};
	assign full   = (fill >= (QCNT_W+1)'(Q_DEPTH));
	assign accept = push && !full;

	// raster position of the next sample
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (cfg_hit) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (col_q == last_col) begin
				col_q <= '0;
				row_q <= (row_q == last_row) ? '0 : row_q + ROW_W'(1);
			end else begin
				col_q <= col_q + COL_W'(1);
			end
		end
	end

	// previous row, kept twice so the center and right taps are read in the same cycle
	hsc_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_WIDTH)) u_prev_mid (
		.clk   (clk),
		.we    (accept),
		.waddr (col_q),
		.wdata (sample),
		.raddr (col_q),
		.rdata (mid)
	);

	hsc_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_WIDTH)) u_prev_rgt (
		.clk   (clk),
		.we    (accept),
		.waddr (col_q),
		.wdata (sample),
		.raddr (col_q + COL_W'(1)),
		.rdata (rgt)
	);

	// row before previous, written in the following cycle with the old center value
	hsc_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_WIDTH)) u_prev_up (
		.clk   (clk),
		.we    (valid_s1),
		.waddr (col_s1),
		.wdata (mid),
		.raddr (col_q),
		.rdata (up)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			col_s1      <= col_q;
			ry_s1       <= row_q - ROW_W'(1);
			has_res_s1  <= (row_q != '0);
			border_s1   <= (row_q == ROW_W'(1)) || (col_q == '0) || (col_q == last_col);
			last_row_s1 <= (row_q == last_row);
			end_s1      <= (row_q == last_row) && (col_q == last_col);
			sample_s1   <= sample;
		end
		if (valid_s1) begin
			lft_q <= mid;
		end
	end

	// 4c + l + r + u + d at full width, then floor divide by eight
	assign sum = (SUM_W'(mid) <<< 2) + SUM_W'(lft_q) + SUM_W'(rgt) + SUM_W'(up)
		+ SUM_W'(sample_s1);

	assign q_push = valid_s1 && has_res_s1;

	always_comb begin
		q_din.value      = border_s1 ? mid : sum[SUM_W-1:3];
		q_din.copy_value = sample_s1;
		q_din.column     = col_s1;
		q_din.row        = ry_s1;
		q_din.two        = last_row_s1;
		q_din.frame_end  = end_s1;
	end

endmodule

FILE: rtl/hsc_back.sv
// ----------------------------------------------------------------------------
// hsc_back
// result stage, expands a queued entry into one or two results
// ----------------------------------------------------------------------------
module hsc_back import hsc_pkg::*; (
	input  logic                        clk,
	input  logic                        arst_n,
	input  q_entry_t                    q_dout,
	input  logic                        q_empty,
	output logic                        q_pop,
	output logic                        empty,
	input  logic                        pop,
	output logic signed [SAMPLE_W-1:0]  cell_value,
	output logic [COL_W-1:0]            cell_column,
	output logic [ROW_W-1:0]            cell_row,
	output logic                        frame_end
);

	q_entry_t ent_q;
	logic     out_valid_q;
	logic     second_q;
	logic     last;
	logic     advance;

	assign last    = !ent_q.two || second_q;
	assign advance = !out_valid_q || (pop && last);
	assign q_pop   = advance && !q_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			second_q    <= 1'b0;
		end else if (advance) begin
			out_valid_q <= !q_empty;
			second_q    <= 1'b0;
		end else if (pop) begin
			second_q    <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			ent_q <= q_dout;
		end
	end

	assign empty       = !out_valid_q;
	assign cell_value  = second_q ? ent_q.copy_value : ent_q.value;
	assign cell_column = ent_q.column;
	assign cell_row    = ent_q.row + ROW_W'(second_q);
	assign frame_end   = second_q && ent_q.frame_end;

endmodule

FILE: rtl/heat_stencil_5point_stream.sv
// each result is formed in s1 with the sample of the row below, then queued and registered
// throughput: one sample per cycle while full is low; on the last row each sample gives two
//   results, so the single result port sets the pace there
// the stencil front reads three line-store rams in the accept cycle and adds in the next
// reset: geometry 1024 x 1024, raster position zero, queues empty; line stores not cleared
// ----------------------------------------------------------------------------
// heat_stencil_5point_stream
// one jacobi step of a 2d five-point heat stencil on a raster sample stream
// ----------------------------------------------------------------------------
module heat_stencil_5point_stream import hsc_pkg::*; (
	input  logic                        clk,
	input  logic                        arst_n,
	// configuration write channel
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [CFG_IDX_W-1:0]        cfg_index,
	input  logic [CFG_DATA_W-1:0]       cfg_data,
	// sample requests in
	input  logic                        push,
	output logic                        full,
	input  logic signed [SAMPLE_W-1:0]  sample,
	// result requests out
	output logic                        empty,
	input  logic                        pop,
	output logic signed [SAMPLE_W-1:0]  cell_value,
	output logic [COL_W-1:0]            cell_column,
	output logic [ROW_W-1:0]            cell_row,
	output logic                        frame_end
);

	// front to queue
	logic              q_push;
	q_entry_t          q_din;
	logic              valid_s1;
	// queue to back
	q_entry_t          q_dout;
	logic              q_empty;
	logic              q_pop;
	logic [QCNT_W-1:0] q_count;

	// front: counters, line stores, border classification and the weighted sum
	hsc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.push      (push),
		.full      (full),
		.sample    (sample),
		.q_count   (q_count),
		.q_push    (q_push),
		.q_din     (q_din),
		.valid_s1  (valid_s1)
	);

	// short queue so a stalled consumer does not stop the stencil right away
	hsc_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_push  (q_push),
		.q_din   (q_din),
		.q_pop   (q_pop),
		.q_dout  (q_dout),
		.q_empty (q_empty),
		.q_count (q_count)
	);

	// back: output register, emits the last-row copy as a second request
	hsc_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_dout      (q_dout),
		.q_empty     (q_empty),
		.q_pop       (q_pop),
		.empty       (empty),
		.pop         (pop),
		.cell_value  (cell_value),
		.cell_column (cell_column),
		.cell_row    (cell_row),
		.frame_end   (frame_end)
	);

	// a full queue must hold off new samples
	a_full_when_queue_full: assert property (@(posedge clk) disable iff (!arst_n)
		(q_count == QCNT_W'(Q_DEPTH)) |-> full)
		else $error("queue full but input not stalled");

	// the queue never takes an entry it has no room for
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_push && !q_pop && q_count == QCNT_W'(Q_DEPTH)))
		else $error("queue overflow");

	// every accepted sample reaches the stencil stage next cycle
	a_accept_to_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !full) |=> valid_s1)
		else $error("accepted sample lost before stencil stage");

endmodule

FILE: verif/heat_stencil_5point_stream_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heat_stencil_5point_stream_tb
// checks every stencil result, border copy and frame marker against a
// line-buffer predictor while both sides of the queue ports stall at random
// ----------------------------------------------------------------------------
module heat_stencil_5point_stream_tb;
	import hsc_pkg::*;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int RANDOM_ITEMS = 130;
	localparam int IDLE_PCT     = 23;
	localparam int SETTLE       = 8;

	localparam logic signed [SAMPLE_W-1:0] S_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
	localparam logic signed [SAMPLE_W-1:0] S_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
	localparam logic signed [SAMPLE_W-1:0] S_NEG1 = '1;
	localparam logic signed [SAMPLE_W-1:0] S_ZERO = '0;
	localparam logic signed [SAMPLE_W-1:0] S_ONE = SAMPLE_W'(1);

	// one updated cell as it should leave the block
	typedef struct {
		logic signed [SAMPLE_W-1:0] value;
		logic [COL_W-1:0]           column;
		logic [ROW_W-1:0]           row;
		logic                       last;
	} cell_result_t;

	logic                       clk;
	logic                       arst_n;
	logic                       cfg_valid;
	logic                       cfg_ready;
	logic [CFG_IDX_W-1:0]       cfg_index;
	logic [CFG_DATA_W-1:0]      cfg_data;
	logic                       push;
	logic                       full;
	logic signed [SAMPLE_W-1:0] sample;
	logic                       empty;
	logic                       pop;
	logic signed [SAMPLE_W-1:0] cell_value;
	logic [COL_W-1:0]           cell_column;
	logic [ROW_W-1:0]           cell_row;
	logic                       frame_end;

	heat_stencil_5point_stream dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.push        (push),
		.full        (full),
		.sample      (sample),
		.empty       (empty),
		.pop         (pop),
		.cell_value  (cell_value),
		.cell_column (cell_column),
		.cell_row    (cell_row),
		.frame_end   (frame_end)
	);

	// predictor state: register copies, line stores and raster position
	logic [GW_W-1:0] grid_w_reg;
	logic [GH_W-1:0] grid_h_reg;
	longint          line_above [MAX_WIDTH];
	longint          line_two_above [MAX_WIDTH];
	longint          west_hold;
	int unsigned     col_pos;
	int unsigned     row_pos;

	cell_result_t pending_cells [$];
	int           mismatches;
	int           hold_pop_cycles;
	bit           steady_flow;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// geometry as the block applies it: out-of-range values are clamped
	function automatic int unsigned active_width();
		if (grid_w_reg < MIN_DIM)
			return MIN_DIM;
		if (grid_w_reg > MAX_WIDTH)
			return MAX_WIDTH;
		return grid_w_reg;
	endfunction

	function automatic int unsigned active_height();
		return (grid_h_reg < MIN_DIM) ? MIN_DIM : grid_h_reg;
	endfunction

	// one jacobi step for the cell one row above the incoming sample
	task automatic predict_stencil(input logic signed [SAMPLE_W-1:0] value);
		int unsigned  w;
		int unsigned  h;
		int unsigned  x;
		int unsigned  y;
		longint       centre;
		longint       north;
		longint       east;
		longint       south;
		longint       acc;
		cell_result_t res;
		w = active_width();
		h = active_height();
		x = (col_pos >= w) ? w - 1 : col_pos;
		y = (row_pos >= h) ? h - 1 : row_pos;
		south = value;
		centre = line_above[x];
		north = line_two_above[x];
		east = (x + 1 < w) ? line_above[x + 1] : 0;
		if (y >= 1) begin
			// border cells pass through, interior cells get (4c+w+e+n+s)>>3
			if (y == 1 || x == 0 || x == w - 1)
				acc = centre;
			else
				acc = (4 * centre + west_hold + east + north + south) >>> 3;
			res.value = SAMPLE_W'(acc);
			res.column = COL_W'(x);
			res.row = ROW_W'(y - 1);
			res.last = 1'b0;
			pending_cells.push_back(res);
			// last row: the input itself is a border cell too
			if (y == h - 1) begin
				res.value = value;
				res.column = COL_W'(x);
				res.row = ROW_W'(y);
				res.last = (x == w - 1);
				pending_cells.push_back(res);
			end
		end
		west_hold = centre;
		line_two_above[x] = centre;
		line_above[x] = south;
		x++;
		if (x >= w) begin
			x = 0;
			y++;
			if (y >= h)
				y = 0;
		end
		col_pos = x;
		row_pos = y;
	endtask

	// register write request; a write to either geometry register restarts the frame
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		if (idx == CFG_GRID_WIDTH)
			grid_w_reg = data[GW_W-1:0];
		else if (idx == CFG_GRID_HEIGHT)
			grid_h_reg = data[GH_W-1:0];
		col_pos = 0;
		row_pos = 0;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// one sample request, with random gaps ahead of it
	task automatic send_sample(input logic signed [SAMPLE_W-1:0] value);
		@(negedge clk);
		while (!steady_flow && $urandom_range(99) < IDLE_PCT) begin
			push <= 1'b0;
			@(negedge clk);
		end
		push <= 1'b1;
		sample <= value;
		@(posedge clk);
		while (full)
			@(posedge clk);
		predict_stencil(value);
	endtask

	task automatic end_burst();
		@(negedge clk);
		push <= 1'b0;
	endtask

	// block idle: all results back, then room for a trailing row-0 sample
	task automatic drain_results();
		while (pending_cells.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// mostly full-range values, with extremes and small values mixed in
	function automatic logic signed [SAMPLE_W-1:0] pick_sample();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 55)
			return SAMPLE_W'($urandom);
		if (r < 75)
			return SAMPLE_W'($urandom_range(4000)) - SAMPLE_W'(2000);
		case ($urandom_range(5))
			0: return S_MAX;
			1: return S_MIN;
			2: return S_NEG1;
			3: return S_ZERO;
			4: return S_MAX - SAMPLE_W'($urandom_range(255));
			default: return S_MIN + SAMPLE_W'($urandom_range(255));
		endcase
	endfunction

	// smallest frame with extremes on every cell, then the wrap into the next frame
	task automatic test_border_extremes();
		logic signed [SAMPLE_W-1:0] vals [9];
		vals = '{S_MAX, S_MIN, S_NEG1, S_MIN, S_MAX, S_ZERO, S_ONE, S_MIN, S_MAX};
		write_reg(CFG_GRID_WIDTH, CFG_DATA_W'(0));
		write_reg(CFG_GRID_HEIGHT, CFG_DATA_W'(2));
		foreach (vals[i])
			send_sample(vals[i]);
		// row 0 of the following frame gives nothing
		repeat (3) send_sample(pick_sample());
		end_burst();
		drain_results();
	endtask

	// a write mid-frame restarts the raster; upper data bits beyond the register drop
	task automatic test_restart_mid_frame();
		write_reg(CFG_GRID_WIDTH, CFG_DATA_W'(16'hF804));
		write_reg(CFG_GRID_HEIGHT, CFG_DATA_W'(4));
		repeat (5) send_sample(pick_sample());
		end_burst();
		drain_results();
		write_reg(CFG_GRID_HEIGHT, CFG_DATA_W'(0));
		repeat (12) send_sample(pick_sample());
		end_burst();
		drain_results();
	endtask

	// widest rows: oversize width clamps to the line store depth
	task automatic test_wide_rows();
		write_reg(CFG_GRID_WIDTH, CFG_DATA_W'(16'h07FF));
		write_reg(CFG_GRID_HEIGHT, CFG_DATA_W'(3));
		repeat (MAX_WIDTH + 4) send_sample(pick_sample());
		end_burst();
		drain_results();
	endtask

	// tallest frame: never reaches its last row here
	task automatic test_tall_grid();
		write_reg(CFG_GRID_WIDTH, CFG_DATA_W'(3));
		write_reg(CFG_GRID_HEIGHT, CFG_DATA_W'(16'hFFFF));
		repeat (30) send_sample(pick_sample());
		end_burst();
		drain_results();
	endtask

	// receiver holds off so the block fills and stalls its input, then the sender waits it out
	task automatic test_backpressure();
		write_reg(CFG_GRID_WIDTH, CFG_DATA_W'(8));
		write_reg(CFG_GRID_HEIGHT, CFG_DATA_W'(5));
		hold_pop_cycles = 200;
		repeat (30) send_sample(pick_sample());
		end_burst();
		while (pending_cells.size() != 0)
			@(posedge clk);
		// same frame continues, no restart
		repeat (20) send_sample(pick_sample());
		end_burst();
		drain_results();
	endtask

	// random geometry per phase, whole frames plus sometimes a cut-off one
	task automatic test_random_frames();
		int unsigned sent;
		int unsigned mode;
		int unsigned r;
		int unsigned cells;
		int unsigned n;
		logic [CFG_DATA_W-1:0] w_data;
		logic [CFG_DATA_W-1:0] h_data;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			// a long stretch in the middle runs with no gaps on either side
			steady_flow = (sent >= 20 && sent < 100);
			r = $urandom_range(99);
			if (r < 10)
				w_data = CFG_DATA_W'($urandom_range(2));
			else if (r < 75)
				w_data = CFG_DATA_W'($urandom_range(10, 3));
			else
				w_data = CFG_DATA_W'($urandom_range(48, 11));
			if ($urandom_range(99) < 20)
				w_data[CFG_DATA_W-1:GW_W] = (CFG_DATA_W-GW_W)'($urandom);
			h_data = ($urandom_range(99) < 10) ? CFG_DATA_W'($urandom_range(2)) :
				CFG_DATA_W'($urandom_range(7, 3));
			mode = $urandom_range(3);
			if (mode != 1)
				write_reg(CFG_GRID_WIDTH, w_data);
			if (mode != 0)
				write_reg(CFG_GRID_HEIGHT, h_data);
			cells = active_width() * active_height();
			n = cells * $urandom_range(2, 1);
			if ($urandom_range(99) < 30)
				n += $urandom_range(cells - 1, 1);
			// the item budget cuts the last frame short
			if (n > RANDOM_ITEMS - sent)
				n = RANDOM_ITEMS - sent;
			repeat (n) send_sample(pick_sample());
			sent += n;
			end_burst();
			drain_results();
		end
		steady_flow = 1'b0;
	endtask

	// receiver: pop requests with random gaps, or a counted hold-off
	initial begin
		pop = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_pop_cycles > 0) begin
				hold_pop_cycles--;
				pop <= 1'b0;
			end else begin
				pop <= steady_flow || ($urandom_range(99) >= IDLE_PCT);
			end
		end
	end

	// every accepted result against the oldest prediction
	initial begin : result_check
		cell_result_t want;
		forever begin
			@(posedge clk);
			if (arst_n && pop && !empty) begin
				if (pending_cells.size() == 0) begin
					$error("unexpected result: cell_value %0d column %0d row %0d",
						cell_value, cell_column, cell_row);
					mismatches++;
				end else begin
					want = pending_cells.pop_front();
					if (cell_value !== want.value) begin
						$error("cell_value: expected %0d, actual %0d", want.value, cell_value);
						mismatches++;
					end
					if (cell_column !== want.column) begin
						$error("cell_column: expected %0d, actual %0d", want.column, cell_column);
						mismatches++;
					end
					if (cell_row !== want.row) begin
						$error("cell_row: expected %0d, actual %0d", want.row, cell_row);
						mismatches++;
					end
					if (frame_end !== want.last) begin
						$error("frame_end: expected %0b, actual %0b", want.last, frame_end);
						mismatches++;
					end
				end
			end
		end
	end

	// hang guard
	initial begin : watchdog
		int unsigned cycles;
		cycles = 0;
		while (cycles <= CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("FAIL");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		push = 1'b0;
		sample = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		mismatches = 0;
		hold_pop_cycles = 0;
		steady_flow = 1'b0;
		// predictor follows the block's reset geometry
		grid_w_reg = GW_W'(RESET_DIM);
		grid_h_reg = GH_W'(RESET_DIM);
		col_pos = 0;
		row_pos = 0;
		west_hold = 0;
		foreach (line_above[i]) begin
			line_above[i] = 0;
			line_two_above[i] = 0;
		end
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_border_extremes();
		test_restart_mid_frame();
		test_wide_rows();
		test_tall_grid();
		test_backpressure();
		test_random_frames();

		// stragglers and late extras
		while (pending_cells.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

FILE: heat_stencil_5point_stream.f
rtl/hsc_pkg.sv
rtl/hsc_ram.sv
rtl/hsc_queue.sv
rtl/hsc_front.sv
rtl/hsc_back.sv
rtl/heat_stencil_5point_stream.sv
verif/heat_stencil_5point_stream_tb.sv
